// ----- rtl/brfifo_pkg.sv -----
// shared constants and helpers for the byte ring fifo
// no dependencies

package brfifo_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH) + 1;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned CAP_MIN = 3;
  localparam int unsigned CAP_RST = 256;
  localparam int unsigned RUN_W   = 9;
  localparam int unsigned RUN_MAX = (1 << RUN_W) - 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // limit a written capacity value to the usable range
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) < CAP_MIN) begin
      r = CNT_W'(CAP_MIN);
    end else if (32'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/brfifo_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

module brfifo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/byte_ring_fifo_with_watermark.sv -----
// byte fifo on a circular ram store with fill count, high-water mark and sticky overflow
// depends on brfifo_pkg and brfifo_ram
// the result of a transaction is strobed in the cycle after it is accepted, unless a configuration write intervenes
// throughput: one transaction per cycle, busy stays low; the ram read port sets the latency
// reset clears pointers, counters and flags and sets capacity to its maximum
// the ram is not cleared; the receiver cannot stall the result strobe

module byte_ring_fifo_with_watermark (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [brfifo_pkg::DATA_W-1:0] data_in,
  input  logic                        last_in,
  input  logic                        cfg_write,
  input  logic [brfifo_pkg::CAP_W-1:0]  cfg_data,
  output logic                        strobe,
  output logic [brfifo_pkg::DATA_W-1:0] data_out,
  output logic                        done_res,
  output logic [brfifo_pkg::RUN_W-1:0]  run_count,
  output logic [brfifo_pkg::CNT_W-1:0]  fill_level,
  output logic [brfifo_pkg::CNT_W-1:0]  max_fill,
  output logic                        overflow
);

  import brfifo_pkg::*;

  logic [CNT_W-1:0]  capacity;
  logic [PTR_W-1:0]  write_ptr, write_ptr_next;
  logic [PTR_W-1:0]  read_ptr, read_ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  high_water, high_water_next;
  logic              overflow_flag, overflow_flag_next;
  logic [RUN_W-1:0]  call_total, call_total_next, run_val;
  logic              accept, wr_ok, rd_ok, ok;
  logic              rd_hit;
  logic [DATA_W-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wr_ok  = accept && (op_t'(op) == OP_WRITE) && (count < capacity);
  assign rd_ok  = accept && (op_t'(op) == OP_READ) && (count != '0);
  assign ok     = wr_ok || rd_ok;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  always_comb begin
    write_ptr_next     = write_ptr;
    read_ptr_next      = read_ptr;
    count_next         = count;
    high_water_next    = high_water;
    overflow_flag_next = overflow_flag;
    if (wr_ok) begin
      write_ptr_next = advance(write_ptr, capacity);
      count_next     = count + CNT_W'(1);
      if (count_next > high_water) begin
        high_water_next = count_next;
      end
    end else if (rd_ok) begin
      read_ptr_next = advance(read_ptr, capacity);
      count_next    = count - CNT_W'(1);
    end
    if (accept && (op_t'(op) == OP_WRITE) && !wr_ok) begin
      overflow_flag_next = 1'b1;
    end
    // saturating per-call count, restarts after the last byte of a call
    run_val = call_total;
    if (ok && (32'(call_total) < RUN_MAX)) begin
      run_val = call_total + RUN_W'(1);
    end
    call_total_next = last_in ? '0 : run_val;
  end

  brfifo_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (write_ptr),
    .wdata (data_in),
    .re    (rd_ok),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= clamp_cap(CAP_W'(CAP_RST));
      write_ptr     <= '0;
      read_ptr      <= '0;
      count         <= '0;
      high_water    <= '0;
      overflow_flag <= 1'b0;
      call_total    <= '0;
      strobe        <= 1'b0;
      rd_hit        <= 1'b0;
    end else if (cfg_write) begin
      capacity      <= clamp_cap(cfg_data);
      write_ptr     <= '0;
      read_ptr      <= '0;
      count         <= '0;
      high_water    <= '0;
      overflow_flag <= 1'b0;
      call_total    <= '0;
      strobe        <= 1'b0;
      rd_hit        <= 1'b0;
    end else begin
      strobe <= accept;
      rd_hit <= rd_ok;
      if (accept) begin
        write_ptr     <= write_ptr_next;
        read_ptr      <= read_ptr_next;
        count         <= count_next;
        high_water    <= high_water_next;
        overflow_flag <= overflow_flag_next;
        call_total    <= call_total_next;
      end
    end
  end

  // result payload, read data comes from the ram output register and reads as zero unless the read succeeded
  always_ff @(posedge clk) begin
    if (accept) begin
      done_res   <= ok;
      run_count  <= run_val;
      fill_level <= count_next;
      max_fill   <= high_water_next;
      overflow   <= overflow_flag_next;
    end
  end

  assign data_out = rd_hit ? ram_rdata : '0;

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_write) |=> strobe)
    else $error("accepted transaction gave no result strobe");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("fill count above capacity");

  a_watermark: assert property (@(posedge clk) disable iff (rst)
    high_water >= count)
    else $error("high-water mark below fill count");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(overflow_flag) && !$past(cfg_write) && !$past(rst)) |-> overflow_flag)
    else $error("overflow flag cleared without configuration write");

  a_read_hit: assert property (@(posedge clk) disable iff (rst)
    rd_hit |-> (strobe && done_res))
    else $error("read data marked without a successful read result");

endmodule
